### hw/rtl/tmp_pkg.sv
package tmp_pkg;

  localparam int DATA_W = 64;
  localparam int OPB_W = 32;

  typedef struct packed {
    logic go;
    logic [DATA_W-1:0] a;
    logic [OPB_W-1:0] b;
  } op_req_t;

  typedef enum logic [10:0] {
    ST_IDLE  = 11'b00000000001,
    ST_IV    = 11'b00000000010,
    ST_VV    = 11'b00000000100,
    ST_XX    = 11'b00000001000,
    ST_BD    = 11'b00000010000,
    ST_VX    = 11'b00000100000,
    ST_DSAMP = 11'b00001000000,
    ST_DACC  = 11'b00010000000,
    ST_DPOS  = 11'b00100000000,
    ST_DVEL  = 11'b01000000000,
    ST_FIN   = 11'b10000000000
  } state_t;

  typedef enum logic [1:0] {
    REG_SPEED = 2'd0,
    REG_START = 2'd1,
    REG_END   = 2'd2
  } reg_idx_t;

endpackage

### hw/rtl/tmp_mul.sv
module tmp_mul (
  input  logic                        clk,
  input  logic                        rst,
  input  tmp_pkg::op_req_t            req,
  output logic                        done,
  output logic [tmp_pkg::DATA_W-1:0]  product
);

  localparam int CNT_W = $clog2(tmp_pkg::OPB_W + 1);

  logic [tmp_pkg::DATA_W-1:0] aa;
  logic [tmp_pkg::OPB_W-1:0] bb;
  logic [CNT_W-1:0] cnt;
  logic busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.go) begin
        product <= '0;
        aa <= req.a;
        bb <= req.b;
        cnt <= CNT_W'(tmp_pkg::OPB_W);
        busy <= 1'b1;
      end else if (busy) begin
        if (bb[0]) begin
          product <= product + aa;
        end
        aa <= {aa[tmp_pkg::DATA_W-2:0], 1'b0};
        bb <= {1'b0, bb[tmp_pkg::OPB_W-1:1]};
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

### hw/rtl/tmp_div.sv
module tmp_div (
  input  logic                        clk,
  input  logic                        rst,
  input  tmp_pkg::op_req_t            req,
  output logic                        done,
  output logic [tmp_pkg::DATA_W-1:0]  quotient,
  output logic [tmp_pkg::OPB_W-1:0]   remainder
);

  localparam int CNT_W = $clog2(tmp_pkg::DATA_W + 1);

  logic [tmp_pkg::OPB_W-1:0] dv;
  logic [CNT_W-1:0] cnt;
  logic busy;
  logic [tmp_pkg::OPB_W:0] rem_sh;
  logic ge;

  assign rem_sh = {remainder, quotient[tmp_pkg::DATA_W-1]};
  assign ge = rem_sh >= {1'b0, dv};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.go) begin
        quotient <= req.a;
        dv <= req.b;
        remainder <= '0;
        cnt <= CNT_W'(tmp_pkg::DATA_W);
        busy <= 1'b1;
      end else if (busy) begin
        remainder <= ge ? tmp_pkg::OPB_W'(rem_sh - {1'b0, dv})
                        : tmp_pkg::OPB_W'(rem_sh);
        quotient <= {quotient[tmp_pkg::DATA_W-2:0], ge};
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

### hw/rtl/trapezoid_motion_profile_core.sv
// The result strobe done rises once the block, after accepting start, has run
// five products on a bit-serial shift-add multiplier (each launched, taken
// through its 32 shift-add steps, then handed over), then four quotients on a
// bit-serial restoring divider (each launched, taken through its 64 steps,
// then handed over), and a final state has formed the outputs. busy is high
// throughout that computation and drops in the cycle that carries done, so a
// new sample can start there. Results appear on the output ports with a
// one-cycle done strobe and are not held off.
module trapezoid_motion_profile_core #(
  parameter int POSITION_BITS = 18,
  parameter int SPEED_BITS = 16,
  parameter int INDEX_BITS = 28
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [3:0]               paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready,
  input  logic                     start,
  output logic                     busy,
  input  logic [INDEX_BITS-1:0]    sample_index,
  output logic                     done,
  output logic signed [31:0]       position_scaled,
  output logic signed [16:0]       velocity,
  output logic signed [31:0]       acceleration,
  output logic [INDEX_BITS-1:0]    move_samples,
  output logic                     in_profile
);

  localparam int W = tmp_pkg::DATA_W;
  localparam int BW = tmp_pkg::OPB_W;

  logic [SPEED_BITS-1:0] speed;
  logic signed [POSITION_BITS-1:0] start_pos;
  logic signed [POSITION_BITS-1:0] end_pos;
  logic [INDEX_BITS-1:0] idx;

  tmp_pkg::state_t state;
  logic issue;
  tmp_pkg::op_req_t mreq, dreq;
  logic mdone, ddone;
  logic [W-1:0] mprod, dquo;
  logic [BW-1:0] drem;

  logic [W-1:0] r_iv, r_vv, r_xx, r_bd, r_vx;
  logic [W-1:0] amag, pmag, vmag, smp;
  logic pos_neg;

  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      speed <= SPEED_BITS'(1);
      start_pos <= '0;
      end_pos <= '0;
    end else if (cfg_wr) begin
      case (tmp_pkg::reg_idx_t'(paddr[3:2]))
        tmp_pkg::REG_SPEED: speed <= pwdata[SPEED_BITS-1:0];
        tmp_pkg::REG_START: start_pos <= pwdata[POSITION_BITS-1:0];
        tmp_pkg::REG_END: end_pos <= pwdata[POSITION_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (tmp_pkg::reg_idx_t'(paddr[3:2]))
      tmp_pkg::REG_SPEED: prdata = 32'(speed);
      tmp_pkg::REG_START: prdata = 32'(start_pos);
      tmp_pkg::REG_END: prdata = 32'(end_pos);
      default: prdata = '0;
    endcase
  end

  logic signed [W-1:0] s64, e64, diff;
  logic neg;
  logic [W-1:0] d64, v64, c150, c500, c650, x;
  logic acc_ph, cru_ph, dec_ph, in_move, dzero;
  logic signed [W-1:0] base, babs, num, numabs;
  logic tpos;

  assign s64 = W'(start_pos);
  assign e64 = W'(end_pos);
  assign diff = e64 - s64;
  assign neg = diff < 0;
  assign d64 = neg ? W'(-diff) : W'(diff);
  assign dzero = d64 == '0;
  assign v64 = W'(speed);
  assign c150 = d64 * W'(150);
  assign c500 = d64 * W'(500);
  assign c650 = d64 * W'(650);
  assign acc_ph = r_iv < c150;
  assign cru_ph = !acc_ph && (r_iv < c500);
  assign dec_ph = !acc_ph && !cru_ph && (r_iv <= c650);
  assign in_move = dzero || acc_ph || cru_ph || dec_ph;
  assign x = acc_ph ? r_iv : c650 - r_iv;
  assign base = acc_ph ? s64 : e64;
  assign babs = (base < 0) ? -base : base;
  assign tpos = (acc_ph && !neg) || (!acc_ph && neg);
  assign num = ((base < 0) ? -signed'(r_bd) : signed'(r_bd))
             + (tpos ? signed'(r_xx) : -signed'(r_xx));
  assign numabs = (num < 0) ? -num : num;

  always_comb begin
    mreq = '0;
    dreq = '0;
    mreq.go = issue && (state == tmp_pkg::ST_IV || state == tmp_pkg::ST_VV
                        || state == tmp_pkg::ST_XX || state == tmp_pkg::ST_BD
                        || state == tmp_pkg::ST_VX);
    dreq.go = issue && (state == tmp_pkg::ST_DSAMP || state == tmp_pkg::ST_DACC
                        || state == tmp_pkg::ST_DPOS || state == tmp_pkg::ST_DVEL);
    case (state)
      tmp_pkg::ST_IV: begin
        mreq.a = W'(idx);
        mreq.b = BW'(speed);
      end
      tmp_pkg::ST_VV: begin
        mreq.a = v64 * W'(10);
        mreq.b = BW'(speed);
      end
      tmp_pkg::ST_XX: begin
        mreq.a = x;
        mreq.b = x[BW-1:0];
      end
      tmp_pkg::ST_BD: begin
        mreq.a = W'(babs) * W'(150000);
        mreq.b = d64[BW-1:0];
      end
      tmp_pkg::ST_VX: begin
        mreq.a = v64;
        mreq.b = x[BW-1:0];
      end
      tmp_pkg::ST_DSAMP: begin
        dreq.a = c650;
        dreq.b = BW'(speed);
      end
      tmp_pkg::ST_DACC: begin
        dreq.a = r_vv;
        dreq.b = BW'(d64 * W'(3));
      end
      tmp_pkg::ST_DPOS: begin
        dreq.a = W'(numabs);
        dreq.b = BW'(d64 * W'(15));
      end
      tmp_pkg::ST_DVEL: begin
        dreq.a = r_vx;
        dreq.b = c150[BW-1:0];
      end
      default: ;
    endcase
  end

  tmp_mul u_mul (.clk(clk), .rst(rst), .req(mreq), .done(mdone), .product(mprod));
  tmp_div u_div (.clk(clk), .rst(rst), .req(dreq), .done(ddone), .quotient(dquo),
                 .remainder(drem));

  logic [BW-1:0] dv_hold;
  logic [W-1:0] qr;
  always_ff @(posedge clk) begin
    if (dreq.go) begin
      dv_hold <= dreq.b;
    end
  end
  assign qr = dquo + W'({1'b0, drem, 1'b0} >= {2'b0, dv_hold});

  logic signed [W-1:0] p_cru, p_fin, pmag_s, cterm;
  logic signed [W-1:0] v_fin, a_fin;
  logic [INDEX_BITS-1:0] smp_fin;

  assign cterm = signed'(r_iv * W'(20)) - signed'(d64 * W'(6500));
  assign p_cru = (s64 + e64) * W'(5000) + (neg ? -cterm : cterm);
  assign pmag_s = signed'(pmag);

  always_comb begin
    p_fin = '0;
    v_fin = '0;
    a_fin = '0;
    if (dzero) begin
      p_fin = s64 * W'(10000);
    end else if (cru_ph) begin
      p_fin = p_cru;
      v_fin = neg ? -signed'(v64) : signed'(v64);
    end else begin
      p_fin = pos_neg ? -pmag_s : pmag_s;
      v_fin = neg ? -signed'(vmag) : signed'(vmag);
      if (acc_ph != neg) begin
        a_fin = (amag > W'(32'h7fffffff)) ? W'(32'h7fffffff) : signed'(amag);
      end else begin
        a_fin = (amag > W'(33'h080000000)) ? -signed'(W'(33'h080000000))
                                           : -signed'(amag);
      end
    end
    if (dzero) begin
      smp_fin = '0;
    end else if (speed == '0) begin
      smp_fin = '1;
    end else if (smp > W'({INDEX_BITS{1'b1}})) begin
      smp_fin = '1;
    end else begin
      smp_fin = smp[INDEX_BITS-1:0];
    end
  end

  assign busy = state != tmp_pkg::ST_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tmp_pkg::ST_IDLE;
      issue <= 1'b0;
      done <= 1'b0;
      position_scaled <= '0;
      velocity <= '0;
      acceleration <= '0;
      move_samples <= '0;
      in_profile <= 1'b0;
    end else begin
      done <= 1'b0;
      if (issue) begin
        issue <= 1'b0;
      end
      case (state)
        tmp_pkg::ST_IDLE: begin
          if (start) begin
            idx <= sample_index;
            state <= tmp_pkg::ST_IV;
            issue <= 1'b1;
          end
        end
        tmp_pkg::ST_IV: if (mdone) begin
          r_iv <= mprod;
          state <= tmp_pkg::ST_VV;
          issue <= 1'b1;
        end
        tmp_pkg::ST_VV: if (mdone) begin
          r_vv <= mprod;
          state <= tmp_pkg::ST_XX;
          issue <= 1'b1;
        end
        tmp_pkg::ST_XX: if (mdone) begin
          r_xx <= mprod;
          state <= tmp_pkg::ST_BD;
          issue <= 1'b1;
        end
        tmp_pkg::ST_BD: if (mdone) begin
          r_bd <= mprod;
          state <= tmp_pkg::ST_VX;
          issue <= 1'b1;
        end
        tmp_pkg::ST_VX: if (mdone) begin
          r_vx <= mprod;
          state <= tmp_pkg::ST_DSAMP;
          issue <= 1'b1;
        end
        tmp_pkg::ST_DSAMP: if (ddone) begin
          smp <= qr;
          state <= tmp_pkg::ST_DACC;
          issue <= 1'b1;
        end
        tmp_pkg::ST_DACC: if (ddone) begin
          amag <= dquo;
          state <= tmp_pkg::ST_DPOS;
          issue <= 1'b1;
        end
        tmp_pkg::ST_DPOS: if (ddone) begin
          pmag <= qr;
          pos_neg <= num < 0;
          state <= tmp_pkg::ST_DVEL;
          issue <= 1'b1;
        end
        tmp_pkg::ST_DVEL: if (ddone) begin
          vmag <= qr;
          state <= tmp_pkg::ST_FIN;
        end
        tmp_pkg::ST_FIN: begin
          if (in_move) begin
            position_scaled <= p_fin[31:0];
            velocity <= v_fin[16:0];
            acceleration <= a_fin[31:0];
          end
          move_samples <= smp_fin;
          in_profile <= in_move;
          done <= 1'b1;
          state <= tmp_pkg::ST_IDLE;
        end
        default: state <= tmp_pkg::ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_done_after_fin: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == tmp_pkg::ST_FIN))
    else $error("done without a finished computation");
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted sample did not make the block busy");
  a_hold_out: assert property (@(posedge clk) disable iff (rst)
    done && !in_profile |-> position_scaled == $past(position_scaled))
    else $error("held position changed outside the move");
  a_one_unit: assert property (@(posedge clk) disable iff (rst)
    !(mreq.go && dreq.go))
    else $error("both arithmetic units launched together");
`endif

endmodule
